/* rtl/pcss_pkg.sv */
package pcss_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 24;

    // point stores and hull stack
    localparam int ST_DEPTH = MAX_POINTS + 1;
    localparam int HS_DEPTH = MAX_POINTS + 2;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int HS_AW    = $clog2(HS_DEPTH);
    localparam int CNT_W    = $clog2(HS_DEPTH + 1);
    localparam int HC_W     = 11;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_HULL = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_NONE  = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic             st_we;
        logic [ST_AW-1:0] st_waddr;
        logic             st_re;
        logic [ST_AW-1:0] st_raddr;
        logic             st_from_stack;
        logic             hs_we;
        logic [HS_AW-1:0] hs_waddr;
        logic [ST_AW-1:0] hs_wdata;
        logic             hs_re;
        logic [HS_AW-1:0] hs_raddr;
        logic             ld_a;
        logic             ld_b;
        logic             ld_c;
        logic             push_sh;
        logic             pop_sh;
        logic             mul_p;
        logic             mul_q;
    } t_dp_cmd;

    typedef struct packed {
        logic [ST_AW-1:0] hs_rdata;
        t_coord           rd_x;
        t_coord           rd_y;
        t_coord           rd_z;
        logic             x_lt;
        logic             x_eq;
        logic             ident_ab;
        logic             ident_bc;
        logic             far_ab;
        logic             turn_neg;
        logic             turn_pos;
    } t_dp_sts;

    typedef struct packed {
        logic             load;
        logic [1:0]       status;
        logic             point_valid;
        logic             last_point;
        logic [CNT_W-1:0] count;
        logic             reversed;
    } t_res;

endpackage

/* rtl/polygon_convexify_stack_scan.sv */
// Polygon convexifier: load points (action 0), compute the hull (action 1), then read
// hull points one per request (action 2); every request gives one result. Points live
// in single-port-read x/y/z memories and the hull in a stack memory of store indices.
// A read goes through a stack read, then a store read, then the result. A compute
// walks the polygon through the one store read port and shares one multiplier: a
// closing check and a leftmost search over N points (N = loaded count, plus one for a
// closing copy), the turn at the leftmost vertex, then a turn test per scanned point
// and per pop; when the input had to be reversed, a second orientation pass runs over
// the hull entries.
// The memories need no clearing after reset. Results sit in an output register, so a new
// request is taken while an earlier result waits.
module polygon_convexify_stack_scan (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_action,
    input  pcss_pkg::t_coord       i_x_coord,
    input  pcss_pkg::t_coord       i_y_coord,
    input  pcss_pkg::t_coord       i_z_coord,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic                   o_point_valid,
    output pcss_pkg::t_coord       o_out_x,
    output pcss_pkg::t_coord       o_out_y,
    output pcss_pkg::t_coord       o_out_z,
    output logic                   o_last_point,
    output logic [pcss_pkg::HC_W-1:0] o_hull_count,
    output logic                   o_was_reversed
);
    import pcss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_res    res;
    logic    out_free;

    // output register
    logic            r_o_valid;
    logic [1:0]      r_o_status;
    logic            r_o_pv, r_o_last, r_o_rev;
    t_coord          r_o_x, r_o_y, r_o_z;
    logic [HC_W-1:0] r_o_count;

    assign out_free = !r_o_valid || !i_stall;

    pcss_ctrl u_ctrl (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .i_action,
        .o_stall,
        .i_out_free(out_free),
        .i_sts(sts),
        .o_cmd(cmd),
        .o_res(res)
    );

    pcss_dp u_dp (
        .i_clk,
        .i_cmd(cmd),
        .i_x(i_x_coord),
        .i_y(i_y_coord),
        .i_z(i_z_coord),
        .o_sts(sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res.load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // coordinates come from the store read register, zero when no point
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_o_status <= res.status;
            r_o_pv     <= res.point_valid;
            r_o_last   <= res.last_point;
            r_o_rev    <= res.reversed;
            r_o_count  <= HC_W'(res.count);
            r_o_x      <= res.point_valid ? sts.rd_x : '0;
            r_o_y      <= res.point_valid ? sts.rd_y : '0;
            r_o_z      <= res.point_valid ? sts.rd_z : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_point_valid  = r_o_pv;
    assign o_out_x        = r_o_x;
    assign o_out_y        = r_o_y;
    assign o_out_z        = r_o_z;
    assign o_last_point   = r_o_last;
    assign o_hull_count   = r_o_count;
    assign o_was_reversed = r_o_rev;

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.load |-> (!r_o_valid || !i_stall))
        else $error("result register overwritten");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while busy");

    // a hull point comes with ok status and a non-empty hull
    a_point_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point_valid) |-> ((o_status == STS_OK) && (o_hull_count != '0)))
        else $error("hull point with bad status or empty hull");

    a_last_has_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_point) |-> o_point_valid)
        else $error("last flag without a point");
`endif

endmodule

/* rtl/pcss_ram.sv */
module pcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcss_dp.sv */
module pcss_dp (
    input  logic              i_clk,
    input  pcss_pkg::t_dp_cmd i_cmd,
    input  pcss_pkg::t_coord  i_x,
    input  pcss_pkg::t_coord  i_y,
    input  pcss_pkg::t_coord  i_z,
    output pcss_pkg::t_dp_sts o_sts
);
    import pcss_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [COORD_BITS-1:0] st_x_q, st_y_q, st_z_q;
    logic [ST_AW-1:0]      hs_q;
    logic [ST_AW-1:0]      st_raddr;
    t_coord                rd_x, rd_y, rd_z;

    // A = stack next-to-top, B = stack top, C = candidate
    t_coord r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [DW-1:0] ux, uy, vx, vy, m_l, m_r;
    logic signed [PW-1:0] m_prod, r_p, r_q;

    assign st_raddr = i_cmd.st_from_stack ? hs_q : i_cmd.st_raddr;

    pcss_ram #(.WIDTH(COORD_BITS), .DEPTH(ST_DEPTH)) u_xs (
        .i_clk, .i_we(i_cmd.st_we), .i_waddr(i_cmd.st_waddr), .i_wdata(i_x),
        .i_re(i_cmd.st_re), .i_raddr(st_raddr), .o_rdata(st_x_q)
    );
    pcss_ram #(.WIDTH(COORD_BITS), .DEPTH(ST_DEPTH)) u_ys (
        .i_clk, .i_we(i_cmd.st_we), .i_waddr(i_cmd.st_waddr), .i_wdata(i_y),
        .i_re(i_cmd.st_re), .i_raddr(st_raddr), .o_rdata(st_y_q)
    );
    pcss_ram #(.WIDTH(COORD_BITS), .DEPTH(ST_DEPTH)) u_zs (
        .i_clk, .i_we(i_cmd.st_we), .i_waddr(i_cmd.st_waddr), .i_wdata(i_z),
        .i_re(i_cmd.st_re), .i_raddr(st_raddr), .o_rdata(st_z_q)
    );
    pcss_ram #(.WIDTH(ST_AW), .DEPTH(HS_DEPTH)) u_hs (
        .i_clk, .i_we(i_cmd.hs_we), .i_waddr(i_cmd.hs_waddr), .i_wdata(i_cmd.hs_wdata),
        .i_re(i_cmd.hs_re), .i_raddr(i_cmd.hs_raddr), .o_rdata(hs_q)
    );

    assign rd_x = $signed(st_x_q);
    assign rd_y = $signed(st_y_q);
    assign rd_z = $signed(st_z_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) begin
            r_ax <= rd_x;
            r_ay <= rd_y;
        end
        if (i_cmd.ld_b) begin
            r_bx <= rd_x;
            r_by <= rd_y;
        end
        if (i_cmd.ld_c) begin
            r_cx <= rd_x;
            r_cy <= rd_y;
        end
        if (i_cmd.push_sh) begin
            r_ax <= r_bx;
            r_ay <= r_by;
            r_bx <= r_cx;
            r_by <= r_cy;
        end
        if (i_cmd.pop_sh) begin
            r_bx <= r_ax;
            r_by <= r_ay;
        end
        if (i_cmd.mul_p) begin
            r_p <= m_prod;
        end
        if (i_cmd.mul_q) begin
            r_q <= m_prod;
        end
    end

    assign ux = $signed({r_bx[COORD_BITS-1], r_bx}) - $signed({r_ax[COORD_BITS-1], r_ax});
    assign uy = $signed({r_by[COORD_BITS-1], r_by}) - $signed({r_ay[COORD_BITS-1], r_ay});
    assign vx = $signed({r_cx[COORD_BITS-1], r_cx}) - $signed({r_bx[COORD_BITS-1], r_bx});
    assign vy = $signed({r_cy[COORD_BITS-1], r_cy}) - $signed({r_by[COORD_BITS-1], r_by});

    // one shared multiplier: ux*vy first, uy*vx on the next cycle
    assign m_l    = i_cmd.mul_q ? uy : ux;
    assign m_r    = i_cmd.mul_q ? vx : vy;
    assign m_prod = PW'(m_l) * PW'(m_r);

    function automatic logic f_small(input logic signed [DW-1:0] d);
        return (d == '0) || (d == DW'(1)) || (d == '1);
    endfunction

    always_comb begin
        o_sts          = '0;
        o_sts.hs_rdata = hs_q;
        o_sts.rd_x     = rd_x;
        o_sts.rd_y     = rd_y;
        o_sts.rd_z     = rd_z;
        o_sts.x_lt     = rd_x < r_ax;
        o_sts.x_eq     = rd_x == r_ax;
        o_sts.ident_ab = (ux == '0) && (uy == '0);
        o_sts.ident_bc = (vx == '0) && (vy == '0);
        // squared distance above one unit
        o_sts.far_ab   = !(((ux == '0) && f_small(uy)) || ((uy == '0) && f_small(ux)));
        o_sts.turn_neg = r_p < r_q;
        o_sts.turn_pos = r_p > r_q;
    end

endmodule

/* rtl/pcss_ctrl.sv */
module pcss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    output logic              o_stall,
    input  logic              i_out_free,
    input  pcss_pkg::t_dp_sts i_sts,
    output pcss_pkg::t_dp_cmd o_cmd,
    output pcss_pkg::t_res    o_res
);
    import pcss_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RES  = 5'd1;
    localparam logic [4:0] S_F0   = 5'd2;
    localparam logic [4:0] S_F1   = 5'd3;
    localparam logic [4:0] S_O1   = 5'd4;
    localparam logic [4:0] S_O2   = 5'd5;
    localparam logic [4:0] S_O3   = 5'd6;
    localparam logic [4:0] S_O4   = 5'd7;
    localparam logic [4:0] S_L2   = 5'd8;
    localparam logic [4:0] S_N0   = 5'd9;
    localparam logic [4:0] S_N1   = 5'd10;
    localparam logic [4:0] S_N2   = 5'd11;
    localparam logic [4:0] S_N3   = 5'd12;
    localparam logic [4:0] S_N4   = 5'd13;
    localparam logic [4:0] S_N6   = 5'd14;
    localparam logic [4:0] S_N7   = 5'd15;
    localparam logic [4:0] S_N8   = 5'd16;
    localparam logic [4:0] S_T1   = 5'd17;
    localparam logic [4:0] S_T2   = 5'd18;
    localparam logic [4:0] S_OE   = 5'd19;
    localparam logic [4:0] S_S0   = 5'd20;
    localparam logic [4:0] S_S1   = 5'd21;
    localparam logic [4:0] S_S2   = 5'd22;
    localparam logic [4:0] S_S3   = 5'd23;
    localparam logic [4:0] S_S4   = 5'd24;
    localparam logic [4:0] S_S5   = 5'd25;
    localparam logic [4:0] S_S6   = 5'd26;
    localparam logic [4:0] S_SE   = 5'd27;
    localparam logic [4:0] S_R2   = 5'd28;

    logic [4:0]       r_state, n_state, r_ret, n_ret;
    logic [CNT_W-1:0] r_fpos, n_fpos;
    logic             r_fstk, n_fstk;
    logic [ST_AW-1:0] r_fidx, n_fidx, r_cidx, n_cidx;
    logic [CNT_W-1:0] r_count, n_count, r_hsize, n_hsize, r_rpos, n_rpos;
    logic             r_in_rev, n_in_rev, r_out_rev, n_out_rev, r_mode, n_mode;
    logic [CNT_W-1:0] r_n, n_n, r_j, n_j, r_first, n_first, r_last, n_last;
    logic [CNT_W-1:0] r_i0, n_i0, r_i1, n_i1, r_i, n_i, r_h, n_h;
    logic [1:0]       r_res_status, n_res_status;
    logic             r_res_valid, n_res_valid, r_res_last, n_res_last;

    logic [CNT_W-1:0] pos_m, s_i0, rd_phys;
    logic [ST_AW-1:0] idx0;
    logic             accept;

    function automatic logic [CNT_W-1:0] f_inc(input logic [CNT_W-1:0] k,
                                               input logic [CNT_W-1:0] n);
        return (k == n - CNT_W'(1)) ? '0 : k + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] f_dec(input logic [CNT_W-1:0] k,
                                               input logic [CNT_W-1:0] n);
        return (k == '0) ? n - CNT_W'(1) : k - CNT_W'(1);
    endfunction

    // position in the point list -> store index (closing copy wraps to 0)
    assign pos_m   = r_in_rev ? (r_n - CNT_W'(1) - r_fpos) : r_fpos;
    assign idx0    = (pos_m < r_count) ? ST_AW'(pos_m) : '0;
    assign s_i0    = r_in_rev ? (r_n - CNT_W'(1) - r_last) : r_first;
    assign rd_phys = r_out_rev ? (r_hsize - CNT_W'(1) - r_rpos) : r_rpos;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = r_state != S_IDLE;

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_fpos       = r_fpos;
        n_fstk       = r_fstk;
        n_fidx       = r_fidx;
        n_cidx       = r_cidx;
        n_count      = r_count;
        n_hsize      = r_hsize;
        n_rpos       = r_rpos;
        n_in_rev     = r_in_rev;
        n_out_rev    = r_out_rev;
        n_mode       = r_mode;
        n_n          = r_n;
        n_j          = r_j;
        n_first      = r_first;
        n_last       = r_last;
        n_i0         = r_i0;
        n_i1         = r_i1;
        n_i          = r_i;
        n_h          = r_h;
        n_res_status = r_res_status;
        n_res_valid  = r_res_valid;
        n_res_last   = r_res_last;
        o_cmd        = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = STS_OK;
                    n_res_valid  = 1'b0;
                    n_res_last   = 1'b0;
                    n_state      = S_RES;
                    case (i_action)
                        ACT_LOAD: begin
                            if (r_count < CNT_W'(MAX_POINTS)) begin
                                o_cmd.st_we    = 1'b1;
                                o_cmd.st_waddr = ST_AW'(r_count);
                                n_count        = r_count + CNT_W'(1);
                            end else begin
                                n_res_status = STS_FULL;
                            end
                        end
                        ACT_HULL: begin
                            if (r_count == '0) begin
                                n_res_status = STS_EMPTY;
                                n_hsize      = '0;
                                n_rpos       = '0;
                                n_in_rev     = 1'b0;
                                n_out_rev    = 1'b0;
                            end else begin
                                n_mode   = 1'b0;
                                n_n      = r_count;
                                n_in_rev = 1'b0;
                                n_state  = S_O1;
                            end
                        end
                        ACT_READ: begin
                            if (r_rpos < r_hsize) begin
                                n_fpos  = rd_phys;
                                n_fstk  = 1'b1;
                                n_ret   = S_R2;
                                n_state = S_F0;
                            end else begin
                                n_res_status = STS_NONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RES: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_F0: begin
                if (r_fstk) begin
                    o_cmd.hs_re    = 1'b1;
                    o_cmd.hs_raddr = HS_AW'(r_fpos);
                    n_state        = S_F1;
                end else begin
                    o_cmd.st_re    = 1'b1;
                    o_cmd.st_raddr = idx0;
                    n_fidx         = idx0;
                    n_state        = r_ret;
                end
            end
            S_F1: begin
                o_cmd.st_re         = 1'b1;
                o_cmd.st_from_stack = 1'b1;
                n_fidx              = i_sts.hs_rdata;
                n_state             = r_ret;
            end
            // orientation: closing check against the last element
            S_O1: begin
                n_fpos  = r_n - CNT_W'(1);
                n_fstk  = r_mode;
                n_ret   = S_O2;
                n_state = S_F0;
            end
            S_O2: begin
                o_cmd.ld_a = 1'b1;
                n_fpos     = '0;
                n_fstk     = r_mode;
                n_ret      = S_O3;
                n_state    = S_F0;
            end
            S_O3: begin
                o_cmd.ld_b = 1'b1;
                n_state    = S_O4;
            end
            S_O4: begin
                if (i_sts.far_ab) begin
                    if (r_mode) begin
                        o_cmd.hs_we    = 1'b1;
                        o_cmd.hs_waddr = HS_AW'(r_n);
                        o_cmd.hs_wdata = r_fidx;
                    end
                    n_n = r_n + CNT_W'(1);
                end
                n_j     = '0;
                n_fpos  = '0;
                n_fstk  = r_mode;
                n_ret   = S_L2;
                n_state = S_F0;
            end
            // leftmost search, first and last tie kept
            S_L2: begin
                if (r_j == '0) begin
                    o_cmd.ld_a = 1'b1;
                    n_first    = '0;
                    n_last     = '0;
                end else if (i_sts.x_lt) begin
                    o_cmd.ld_a = 1'b1;
                    n_first    = r_j;
                    n_last     = r_j;
                end else if (i_sts.x_eq) begin
                    n_last = r_j;
                end
                if (r_j == r_n - CNT_W'(1)) begin
                    n_state = S_N0;
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_fpos  = r_j + CNT_W'(1);
                    n_fstk  = r_mode;
                    n_ret   = S_L2;
                    n_state = S_F0;
                end
            end
            S_N0: begin
                n_i1    = f_inc(r_first, r_n);
                n_i0    = f_dec(r_first, r_n);
                n_fpos  = r_first;
                n_fstk  = r_mode;
                n_ret   = S_N1;
                n_state = S_F0;
            end
            S_N1: begin
                o_cmd.ld_b = 1'b1;
                n_fpos     = r_i1;
                n_fstk     = r_mode;
                n_ret      = S_N2;
                n_state    = S_F0;
            end
            S_N2: begin
                o_cmd.ld_c = 1'b1;
                n_state    = S_N3;
            end
            S_N3: begin
                n_fstk  = r_mode;
                n_state = S_F0;
                if (i_sts.ident_bc) begin
                    n_fpos = f_inc(r_i1, r_n);
                    n_ret  = S_N4;
                end else begin
                    n_fpos = r_i0;
                    n_ret  = S_N6;
                end
            end
            S_N4: begin
                o_cmd.ld_c = 1'b1;
                n_fpos     = r_i0;
                n_fstk     = r_mode;
                n_ret      = S_N6;
                n_state    = S_F0;
            end
            S_N6: begin
                o_cmd.ld_a = 1'b1;
                n_state    = S_N7;
            end
            S_N7: begin
                if (i_sts.ident_ab) begin
                    n_fpos  = f_dec(r_i0, r_n);
                    n_fstk  = r_mode;
                    n_ret   = S_N8;
                    n_state = S_F0;
                end else begin
                    n_ret   = S_OE;
                    n_state = S_T1;
                end
            end
            S_N8: begin
                o_cmd.ld_a = 1'b1;
                n_ret      = S_OE;
                n_state    = S_T1;
            end
            S_T1: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_T2;
            end
            S_T2: begin
                o_cmd.mul_q = 1'b1;
                n_state     = r_ret;
            end
            S_OE: begin
                if (r_mode) begin
                    n_out_rev    = i_sts.turn_pos;
                    n_hsize      = r_n;
                    n_rpos       = '0;
                    n_res_status = STS_OK;
                    n_state      = S_RES;
                end else begin
                    n_in_rev = i_sts.turn_neg;
                    n_state  = S_S0;
                end
            end
            // stack scan
            S_S0: begin
                n_i0    = s_i0;
                n_fpos  = s_i0;
                n_fstk  = 1'b0;
                n_ret   = S_S1;
                n_state = S_F0;
            end
            S_S1: begin
                o_cmd.ld_a     = 1'b1;
                o_cmd.hs_we    = 1'b1;
                o_cmd.hs_waddr = '0;
                o_cmd.hs_wdata = r_fidx;
                n_i1           = f_inc(r_i0, r_n);
                n_fpos         = f_inc(r_i0, r_n);
                n_fstk         = 1'b0;
                n_ret          = S_S2;
                n_state        = S_F0;
            end
            S_S2: begin
                o_cmd.ld_b     = 1'b1;
                o_cmd.hs_we    = 1'b1;
                o_cmd.hs_waddr = HS_AW'(1);
                o_cmd.hs_wdata = r_fidx;
                n_h            = CNT_W'(2);
                n_i            = f_inc(r_i1, r_n);
                n_state        = S_S3;
            end
            S_S3: begin
                if (r_i == r_i0) begin
                    n_state = S_SE;
                end else begin
                    n_fpos  = r_i;
                    n_fstk  = 1'b0;
                    n_ret   = S_S4;
                    n_state = S_F0;
                end
            end
            S_S4: begin
                o_cmd.ld_c = 1'b1;
                n_cidx     = r_fidx;
                n_ret      = S_S5;
                n_state    = S_T1;
            end
            S_S5: begin
                if ((r_h > CNT_W'(1)) && i_sts.turn_neg) begin
                    o_cmd.pop_sh = 1'b1;
                    n_h          = r_h - CNT_W'(1);
                    if (r_h > CNT_W'(2)) begin
                        n_fpos  = r_h - CNT_W'(3);
                        n_fstk  = 1'b1;
                        n_ret   = S_S6;
                        n_state = S_F0;
                    end
                end else begin
                    o_cmd.hs_we    = 1'b1;
                    o_cmd.hs_waddr = HS_AW'(r_h);
                    o_cmd.hs_wdata = r_cidx;
                    o_cmd.push_sh  = 1'b1;
                    n_h            = r_h + CNT_W'(1);
                    n_i            = f_inc(r_i, r_n);
                    n_state        = S_S3;
                end
            end
            S_S6: begin
                o_cmd.ld_a = 1'b1;
                n_ret      = S_S5;
                n_state    = S_T1;
            end
            S_SE: begin
                if (r_in_rev) begin
                    n_mode  = 1'b1;
                    n_n     = r_h;
                    n_state = S_O1;
                end else begin
                    n_out_rev    = 1'b0;
                    n_hsize      = r_h;
                    n_rpos       = '0;
                    n_res_status = STS_OK;
                    n_state      = S_RES;
                end
            end
            S_R2: begin
                n_res_valid = 1'b1;
                n_res_last  = (r_rpos + CNT_W'(1)) == r_hsize;
                n_rpos      = r_rpos + CNT_W'(1);
                n_state     = S_RES;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_hsize   <= '0;
            r_rpos    <= '0;
            r_in_rev  <= 1'b0;
            r_out_rev <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_hsize   <= n_hsize;
            r_rpos    <= n_rpos;
            r_in_rev  <= n_in_rev;
            r_out_rev <= n_out_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret        <= n_ret;
        r_fpos       <= n_fpos;
        r_fstk       <= n_fstk;
        r_fidx       <= n_fidx;
        r_cidx       <= n_cidx;
        r_mode       <= n_mode;
        r_n          <= n_n;
        r_j          <= n_j;
        r_first      <= n_first;
        r_last       <= n_last;
        r_i0         <= n_i0;
        r_i1         <= n_i1;
        r_i          <= n_i;
        r_h          <= n_h;
        r_res_status <= n_res_status;
        r_res_valid  <= n_res_valid;
        r_res_last   <= n_res_last;
    end

    always_comb begin
        o_res             = '0;
        o_res.load        = (r_state == S_RES) && i_out_free;
        o_res.status      = r_res_status;
        o_res.point_valid = r_res_valid;
        o_res.last_point  = r_res_last;
        o_res.count       = r_hsize;
        o_res.reversed    = r_in_rev;
    end

endmodule
